// File: rtl/mbp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbp_pkg
// Shared types, constants and helper functions of the Markov background block.
// ---------------------------------------------------------------------------
package mbp_pkg;

   localparam int PROB_FRAC_BITS_DEF = 16;
   localparam int TABLE_WORDS        = 84;
   localparam int DINUC_BASE         = 4;
   localparam int COND_BASE          = 20;
   localparam int QUEUE_DEPTH        = 4;
   localparam int PROB_W             = 24;
   localparam int DEN_W              = 24;
   localparam int SUM0_W             = 18;
   localparam int SUM1_W             = 20;
   localparam int SUM2_W             = 22;

   localparam logic [7:0] CHAR_GAP   = 8'h2D;
   localparam logic [4:0] SET_BAD    = 5'h10;

   localparam logic [6:0] END_ORDER0 = 7'd3;
   localparam logic [6:0] END_DINUC  = 7'd19;
   localparam logic [6:0] END_COND   = 7'd83;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_WRITTEN  = 3'd1,
      ST_GAP      = 3'd2,
      ST_UNKNOWN  = 3'd3,
      ST_ZERO_DIV = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      JOB_WRITE = 2'd0,
      JOB_CHAR  = 2'd1,
      JOB_ERR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_LATER  = 2'd2
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] addr;
      logic [15:0] value;
      logic [4:0] base_set;
      logic [3:0] cur;
      logic [3:0] prev;
      logic [3:0] pprev;
      phase_type  phase;
      logic [2:0] n0;
      logic [4:0] n1;
      logic [6:0] n2;
      status_type status;
   } job_type;

   // Bit 4 of the result flags a character that the letter table does not decode.
   function automatic logic [4:0] decode_letter(input logic [7:0] ch);
      logic [7:0] up;
      logic [4:0] r;
      up = ch;
      if (ch >= 8'h61 && ch <= 8'h7A) begin
         up = ch - 8'h20;
      end
      unique case (up)
         8'h41:   r = 5'h01;
         8'h42:   r = 5'h0E;
         8'h43:   r = 5'h02;
         8'h44:   r = 5'h0D;
         8'h47:   r = 5'h04;
         8'h48:   r = 5'h0B;
         8'h4B:   r = 5'h0C;
         8'h4D:   r = 5'h03;
         8'h4E:   r = 5'h0F;
         8'h52:   r = 5'h05;
         8'h53:   r = 5'h06;
         8'h54:   r = 5'h08;
         8'h55:   r = 5'h00;
         8'h56:   r = 5'h07;
         8'h57:   r = 5'h09;
         8'h58:   r = 5'h00;
         8'h59:   r = 5'h0A;
         default: r = SET_BAD;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] complement_set(input logic [3:0] s);
      return {s[0], s[1], s[2], s[3]};
   endfunction

   function automatic logic [2:0] pop4(input logic [3:0] s);
      return 3'(s[0]) + 3'(s[1]) + 3'(s[2]) + 3'(s[3]);
   endfunction

endpackage

// File: rtl/mbp_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbp_front
// Accepts beats, decodes characters and tracks the sequence context.
// ---------------------------------------------------------------------------
module mbp_front import mbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [6:0]  req_table_addr,
   input  logic [15:0] req_table_value,
   input  logic [7:0]  req_symbol,
   input  logic        req_seq_start,
   input  logic        reverse,
   input  logic        queue_full,
   output logic        push,
   output job_type     job
);

   logic [3:0] prev_ff, prev_in;
   logic [3:0] pprev_ff, pprev_in;
   phase_type  phase_ff, phase_in;
   logic [4:0] dec;
   logic [3:0] cur;
   logic       lower;
   logic [2:0] n0, np, npp;
   logic [4:0] n1;
   phase_type  phase_eff;

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   always_comb begin
      dec       = decode_letter(req_symbol);
      lower     = (req_symbol >= 8'h61) && (req_symbol <= 8'h7A);
      cur       = reverse ? complement_set(dec[3:0]) : dec[3:0];
      phase_eff = req_seq_start ? PH_FIRST : phase_ff;
      n0        = pop4(cur);
      np        = pop4(prev_ff);
      npp       = pop4(pprev_ff);
      n1        = 5'(np) * 5'(n0);

      job          = '0;
      job.addr     = req_table_addr;
      job.value    = req_table_value;
      job.cur      = cur;
      job.prev     = prev_ff;
      job.pprev    = pprev_ff;
      job.phase    = phase_eff;
      job.n0       = n0;
      job.n1       = n1;
      job.n2       = 7'(npp) * 7'(n1);
      job.base_set = {lower, cur};
      job.status   = ST_OK;
      if (!req_func) begin
         job.kind     = JOB_WRITE;
         job.base_set = '0;
         job.status   = ST_WRITTEN;
      end else if (dec[4]) begin
         job.kind     = JOB_ERR;
         job.base_set = '0;
         job.status   = (req_symbol == CHAR_GAP) ? ST_GAP : ST_UNKNOWN;
      end else begin
         job.kind = JOB_CHAR;
      end

      prev_in  = prev_ff;
      pprev_in = pprev_ff;
      phase_in = phase_ff;
      if (push && req_func && !dec[4]) begin
         pprev_in = prev_ff;
         prev_in  = cur;
         phase_in = (phase_eff == PH_FIRST) ? PH_SECOND : PH_LATER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         pprev_ff <= '0;
         phase_ff <= PH_FIRST;
      end else begin
         prev_ff  <= prev_in;
         pprev_ff <= pprev_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// File: rtl/mbp_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbp_queue
// Small first-in first-out queue of decoded jobs between front and back.
// ---------------------------------------------------------------------------
module mbp_queue import mbp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type din,
   output logic    full,
   input  logic    pop,
   output job_type dout,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign dout  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= din;
      end
   end

endmodule

// File: rtl/mbp_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbp_back
// Holds the probability table, sums the matching terms one per cycle and
// divides with a bit-serial restoring divider.
// ---------------------------------------------------------------------------
module mbp_back import mbp_pkg::*; #(
   parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  job_type             job,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PROB_W-1:0]   rsp_position_prob,
   output logic [4:0]          rsp_base_set,
   output logic [2:0]          rsp_status
);

   localparam int NUM_W = PROB_W + PROB_FRAC_BITS;
   localparam int BIT_W = $clog2(NUM_W + 1);

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SETUP, S_DIV, S_OUT} state_type;

   state_type           state_ff;
   job_type             job_ff;
   logic [15:0]         mem [TABLE_WORDS];
   logic [15:0]         rd_data_ff;
   logic [6:0]          idx_ff, end_idx;
   logic                issue_ff;
   logic                tag_valid_ff, tag_hit_ff, tag_last_ff;
   logic [1:0]          tag_class_ff, cls;
   logic                hit;
   logic [5:0]          cidx;
   logic [3:0]          didx;
   logic [SUM0_W-1:0]   sum0_ff;
   logic [SUM1_W-1:0]   sum1_ff;
   logic [SUM2_W-1:0]   sum2_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [DEN_W-1:0]    rem_ff;
   logic [BIT_W-1:0]    bit_ff;
   logic [DEN_W:0]      trial;
   logic                fits;
   logic [22:0]         num_prod, den_prod;
   logic [PROB_W-1:0]   res_prob_ff;
   status_type          res_status_ff;
   logic                rsp_valid_ff;
   logic [PROB_W-1:0]   rsp_prob_ff;
   logic [4:0]          rsp_set_ff;
   logic [2:0]          rsp_status_ff;
   logic                out_free;
   logic                rsp_load;

   assign out_free          = ~rsp_valid_ff | ~rsp_stall;
   assign pop               = (state_ff == S_IDLE) & ~empty & out_free;
   assign rsp_load          = (pop & (job.kind != JOB_CHAR)) |
                              ((state_ff == S_OUT) & out_free);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position_prob = rsp_prob_ff;
   assign rsp_base_set      = rsp_set_ff;
   assign rsp_status        = rsp_status_ff;

   // Walk the table linearly: order-0 words first, then pairs, then triples.
   always_comb begin
      didx = 4'(idx_ff - 7'(DINUC_BASE));
      cidx = 6'(idx_ff - 7'(COND_BASE));
      if (idx_ff < 7'(DINUC_BASE)) begin
         cls = 2'd0;
         hit = job_ff.cur[idx_ff[1:0]];
      end else if (idx_ff < 7'(COND_BASE)) begin
         cls = 2'd1;
         hit = job_ff.prev[didx[3:2]] & job_ff.cur[didx[1:0]];
      end else begin
         cls = 2'd2;
         hit = job_ff.pprev[cidx[5:4]] & job_ff.prev[cidx[3:2]] & job_ff.cur[cidx[1:0]];
      end
      unique case (job_ff.phase)
         PH_FIRST:  end_idx = END_ORDER0;
         PH_SECOND: end_idx = END_DINUC;
         default:   end_idx = END_COND;
      endcase
      trial    = {rem_ff, num_ff[NUM_W-1]};
      fits     = (trial >= {1'b0, den_ff});
      num_prod = 23'(sum1_ff) * 23'(job_ff.n0);
      den_prod = 23'(job_ff.n1) * 23'(sum0_ff);
   end

   always_ff @(posedge clock) begin
      if (pop && job.kind == JOB_WRITE && job.addr < 7'(TABLE_WORDS)) begin
         mem[job.addr] <= job.value;
      end
      rd_data_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
         tag_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  job_ff <= job;
                  if (job.kind == JOB_CHAR) begin
                     idx_ff   <= '0;
                     issue_ff <= 1'b1;
                     sum0_ff  <= '0;
                     sum1_ff  <= '0;
                     sum2_ff  <= '0;
                     state_ff <= S_SCAN;
                  end else begin
                     rsp_prob_ff   <= '0;
                     rsp_set_ff    <= job.base_set;
                     rsp_status_ff <= job.status;
                  end
               end
            end
            S_SCAN: begin
               tag_valid_ff <= issue_ff;
               tag_class_ff <= cls;
               tag_hit_ff   <= hit;
               tag_last_ff  <= (idx_ff == end_idx);
               if (issue_ff) begin
                  if (idx_ff == end_idx) begin
                     issue_ff <= 1'b0;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
               if (tag_valid_ff && tag_hit_ff) begin
                  unique case (tag_class_ff)
                     2'd0:    sum0_ff <= sum0_ff + SUM0_W'(rd_data_ff);
                     2'd1:    sum1_ff <= sum1_ff + SUM1_W'(rd_data_ff);
                     default: sum2_ff <= sum2_ff + SUM2_W'(rd_data_ff);
                  endcase
               end
               // The last word was issued in the cycle before, so issue_ff is low here.
               if (tag_valid_ff && tag_last_ff) begin
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               res_prob_ff <= '0;
               rem_ff      <= '0;
               bit_ff      <= '0;
               unique case (job_ff.phase)
                  PH_FIRST: begin
                     num_ff        <= NUM_W'(sum0_ff);
                     den_ff        <= DEN_W'(job_ff.n0);
                     res_status_ff <= ST_OK;
                     state_ff      <= (job_ff.n0 == '0) ? S_OUT : S_DIV;
                  end
                  PH_SECOND: begin
                     num_ff        <= NUM_W'(num_prod) << PROB_FRAC_BITS;
                     den_ff        <= DEN_W'(den_prod);
                     res_status_ff <= (sum0_ff == '0) ? ST_ZERO_DIV : ST_OK;
                     state_ff      <= (sum0_ff == '0 || job_ff.n1 == '0) ? S_OUT : S_DIV;
                  end
                  default: begin
                     num_ff        <= NUM_W'(sum2_ff);
                     den_ff        <= DEN_W'(job_ff.n2);
                     res_status_ff <= ST_OK;
                     state_ff      <= (job_ff.n2 == '0) ? S_OUT : S_DIV;
                  end
               endcase
            end
            S_DIV: begin
               if (bit_ff == BIT_W'(NUM_W)) begin
                  res_prob_ff <= (|num_ff[NUM_W-1:PROB_W]) ? '1 : num_ff[PROB_W-1:0];
                  state_ff    <= S_OUT;
               end else begin
                  // The quotient bits shift in where the numerator shifts out.
                  rem_ff <= fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
                  num_ff <= {num_ff[NUM_W-2:0], fits};
                  bit_ff <= bit_ff + 1'b1;
               end
            end
            default: begin
               if (out_free) begin
                  rsp_prob_ff   <= res_prob_ff;
                  rsp_set_ff    <= job_ff.base_set;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
         endcase
      end
   end

endmodule

// File: rtl/markov_background_prob.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// markov_background_prob
// Second-order Markov background probability over IUPAC nucleotide streams.
//
//   channel   ports                        direction  handshake
//   req       req_func .. req_seq_start    in         req_valid / req_stall
//   rsp       rsp_position_prob .. status  out        rsp_valid / rsp_stall
//   csr       psel penable pwrite paddr    in         pready always high
//
// A table write or a bad character never leaves the idle state of the back
// end; its result beat is loaded into the output register when its job is
// popped. For a character the back end scans the table words through the
// read pipeline (4, 20 or 84 words for positions 0, 1 and later), sets up
// the bit-serial divider, runs it and then outputs the result. The divider
// is skipped when the term count or, at position 1, the order-0 sum is zero.
// The front accepts beats while the job queue has room, so it runs ahead.
// Reset is synchronous; the table itself is not cleared.
// ---------------------------------------------------------------------------
module markov_background_prob import mbp_pkg::*; #(
   parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [6:0]        req_table_addr,
   input  logic [15:0]       req_table_value,
   input  logic [7:0]        req_symbol,
   input  logic              req_seq_start,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PROB_W-1:0] rsp_position_prob,
   output logic [4:0]        rsp_base_set,
   output logic [2:0]        rsp_status,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam logic [2:0] REG_REVERSE = 3'd0;

   logic    reverse_ff;
   logic    push, pop, full, empty;
   job_type fjob, qjob;

   assign pready = 1'b1;
   assign prdata = (paddr == REG_REVERSE) ? {31'd0, reverse_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
      end else if (psel && penable && pwrite && paddr == REG_REVERSE) begin
         reverse_ff <= pwdata[0];
      end
   end

   mbp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_table_addr  (req_table_addr),
      .req_table_value (req_table_value),
      .req_symbol      (req_symbol),
      .req_seq_start   (req_seq_start),
      .reverse         (reverse_ff),
      .queue_full      (full),
      .push            (push),
      .job             (fjob)
   );

   mbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (fjob),
      .full  (full),
      .pop   (pop),
      .dout  (qjob),
      .empty (empty)
   );

   mbp_back #(.PROB_FRAC_BITS(PROB_FRAC_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .job               (qjob),
      .empty             (empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_position_prob (rsp_position_prob),
      .rsp_base_set      (rsp_base_set),
      .rsp_status        (rsp_status)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Markov background probability testbench
// Loads the probability table, runs directed letters, special cases and
// back-pressure, then random sequences across reverse-complement settings.
// Every response beat is checked against an in-bench model of the block.
// ---------------------------------------------------------------------------
module testbench;
   import mbp_pkg::*;

   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  SETTLE      = 200;
   localparam int  HOLD_CYCLES = 400;
   localparam int  FRAC        = 16;
   localparam logic [2:0] REG_REVERSE = 3'd0;

   typedef struct packed {
      logic [23:0] prob;
      logic [4:0]  bases;
      status_type  status;
   } outcome_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_func = 0;
   logic [6:0]  req_table_addr = 0;
   logic [15:0] req_table_value = 0;
   logic [7:0]  req_symbol = 0;
   logic        req_seq_start = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [23:0] rsp_position_prob;
   logic [4:0]  rsp_base_set;
   logic [2:0]  rsp_status;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [2:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   // Model state of the block.
   logic [15:0] prob_words [TABLE_WORDS];
   logic [3:0]  last_set, second_last_set;
   logic [1:0]  seq_phase;
   logic        rev_mode;

   outcome_type pending_outcomes [$];
   int          mismatches = 0;
   int          cycles = 0;
   int          hold_token = 0, hold_seen = 0, hold_left = 0, stall_run = 0;
   bit          rsp_steady = 0;
   bit          send_steady = 0;

   markov_background_prob uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver side: random stalls, with a long hold-off when the test asks.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else if (stall_run > 0) begin
         stall_run <= stall_run - 1;
         rsp_stall <= 1;
      end else if (rsp_steady || $urandom_range(99) < 65) begin
         rsp_stall <= 0;
      end else begin
         rsp_stall <= 1;
         stall_run <= ($urandom_range(19) == 0) ? $urandom_range(60, 20)
                                                : $urandom_range(2);
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected beat", rsp_status, 0);
         end else begin
            outcome_type want;
            want = pending_outcomes.pop_front();
            if (rsp_position_prob !== want.prob)
               report_mismatch("position_prob", rsp_position_prob, want.prob);
            if (rsp_base_set !== want.bases)
               report_mismatch("base_set", rsp_base_set, want.bases);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // IUPAC letter to base set; bit 4 set means the letter has no code.
   function automatic logic [4:0] iupac_bases(input logic [7:0] up);
      case (up)
         "A": return 5'h01;  "B": return 5'h0E;  "C": return 5'h02;
         "D": return 5'h0D;  "G": return 5'h04;  "H": return 5'h0B;
         "K": return 5'h0C;  "M": return 5'h03;  "N": return 5'h0F;
         "R": return 5'h05;  "S": return 5'h06;  "T": return 5'h08;
         "U": return 5'h00;  "V": return 5'h07;  "W": return 5'h09;
         "X": return 5'h00;  "Y": return 5'h0A;
         default: return 5'h10;
      endcase
   endfunction

   function automatic int ones(input logic [3:0] s);
      return int'(s[0]) + int'(s[1]) + int'(s[2]) + int'(s[3]);
   endfunction

   function automatic outcome_type background_prob_predict(input logic func,
         input logic [6:0] addr, input logic [15:0] value, input logic [7:0] sym,
         input logic start);
      outcome_type r;
      logic [4:0] dec;
      logic [3:0] cur;
      logic       lower;
      logic [1:0] ph;
      longint unsigned s0, s1, s2, q;
      int n0, n1, n2;
      r = '0;
      s0 = 0; s1 = 0; s2 = 0; q = 0;
      lower = 0;
      if (!func) begin
         if (addr < TABLE_WORDS) prob_words[addr] = value;
         r.status = ST_WRITTEN;
         return r;
      end
      if (sym >= "a" && sym <= "z") begin
         lower = 1;
         dec = iupac_bases(sym - 8'h20);
      end else if (sym >= "A" && sym <= "Z") begin
         dec = iupac_bases(sym);
      end else begin
         dec = 5'h10;
      end
      if (dec[4]) begin
         r.status = (sym == CHAR_GAP) ? ST_GAP : ST_UNKNOWN;
         return r;
      end
      cur = rev_mode ? {dec[0], dec[1], dec[2], dec[3]} : dec[3:0];
      ph = start ? 2'd0 : seq_phase;
      n0 = ones(cur);
      r.status = ST_OK;
      for (int k = 0; k < 4; k++) if (cur[k]) s0 += prob_words[k];
      if (ph == 0) begin
         if (n0 != 0) q = s0 / n0;
      end else if (ph == 1) begin
         n1 = ones(last_set) * n0;
         for (int i = 0; i < 4; i++)
            for (int k = 0; k < 4; k++)
               if (last_set[i] && cur[k]) s1 += prob_words[DINUC_BASE + i * 4 + k];
         if (s0 == 0) r.status = ST_ZERO_DIV;
         else if (n1 != 0) q = ((s1 * n0) << FRAC) / (longint'(n1) * s0);
      end else begin
         n2 = ones(second_last_set) * ones(last_set) * n0;
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
               for (int k = 0; k < 4; k++)
                  if (second_last_set[i] && last_set[j] && cur[k])
                     s2 += prob_words[COND_BASE + (i * 4 + j) * 4 + k];
         if (n2 != 0) q = s2 / n2;
      end
      if (q > 64'hFFFFFF) q = 64'hFFFFFF;
      second_last_set = last_set;
      last_set = cur;
      seq_phase = (ph < 2'd2) ? ph + 2'd1 : 2'd2;
      r.prob = q[23:0];
      r.bases = {lower, cur};
      return r;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (send_steady || p < 60) return 0;
      if (p < 90) return $urandom_range(3, 1);
      if (p < 98) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic send_item(input logic func, input logic [6:0] addr,
         input logic [15:0] value, input logic [7:0] sym, input logic start);
      int gap;
      req_valid <= 1;
      req_func <= func;
      req_table_addr <= addr;
      req_table_value <= value;
      req_symbol <= sym;
      req_seq_start <= start;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(background_prob_predict(func, addr, value, sym, start));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_word(input int addr, input logic [15:0] value);
      send_item(0, addr[6:0], value, 8'($urandom), 1'($urandom_range(1)));
   endtask

   task automatic send_char(input logic [7:0] sym, input logic start);
      send_item(1, 7'($urandom), 16'($urandom), sym, start);
   endtask

   task automatic wait_drain();
      req_valid <= 0;
      while (pending_outcomes.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_reverse(input logic on);
      wait_drain();
      psel <= 1; pwrite <= 1; penable <= 0; paddr <= REG_REVERSE; pwdata <= {31'($urandom), on};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      rev_mode = on;
      @(posedge clock);
   endtask

   function automatic logic [15:0] random_word();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] random_letter();
      logic [7:0] c;
      logic [4:0] d;
      do begin
         c = 8'($urandom_range("Z", "A"));
         d = iupac_bases(c);
      end while (d[4]);
      if ($urandom_range(1)) c = c + 8'h20;
      return c;
   endfunction

   task automatic test_table_load();
      for (int a = 0; a < TABLE_WORDS; a++)
         write_word(a, (a == 1) ? 16'hFFFF : (a == 5) ? 16'h0000 : 16'($urandom));
      write_word(127, 16'h5A5A);   // beyond the table: ignored
      write_word(84, 16'hFFFF);
   endtask

   task automatic test_letters();
      for (int r = 0; r < 2; r++) begin
         set_reverse(r[0]);
         for (int c = "A"; c <= "Z"; c++) send_char(8'(c), c == "A");
         for (int c = "a"; c <= "z"; c++) send_char(8'(c), 0);
      end
      set_reverse(0);
   endtask

   task automatic test_special_cases();
      // Gap and unknown characters, with and without a start mark.
      send_char("A", 1);
      send_char(CHAR_GAP, 1);
      send_char("C", 0);
      send_char(8'h00, 0);
      send_char(8'hFF, 1);
      send_char("@", 0);
      send_char("[", 0);
      send_char("G", 0);
      // Empty sets at each position; empty current set at position 1.
      send_char("U", 1);
      send_char("x", 0);
      send_char("N", 0);
      // Zero order-0 entries give a zero divisor at position 1.
      write_word(0, 16'h0000);
      write_word(4, 16'hFFFF);
      send_char("T", 1);
      send_char("a", 0);
      send_char("c", 0);
      // Tiny order-0 against large pairs saturates.
      write_word(0, 16'h0001);
      write_word(4 + 3 * 4, 16'hFFFF);
      send_char("t", 1);
      send_char("A", 0);
   endtask

   task automatic test_backpressure();
      hold_token++;
      send_steady = 1;
      for (int i = 0; i < 30; i++) send_char(random_letter(), i == 0);
      send_steady = 0;
      wait_drain();
   endtask

   task automatic test_random(input int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         if (($urandom_range(9)) == 0) begin
            set_reverse(1'($urandom_range(1)));
            rsp_steady = ($urandom_range(3) == 0);
            send_steady = ($urandom_range(3) == 0);
         end
         send_char(random_letter(), 1);
         sent++;
         repeat ($urandom_range(20, 2)) begin
            case ($urandom_range(19))
               0: write_word($urandom_range(127), random_word());
               1: send_char(8'($urandom), 1'($urandom_range(1)));
               2: send_char(CHAR_GAP, 1'($urandom_range(1)));
               default: send_char(random_letter(), ($urandom_range(30) == 0));
            endcase
            sent++;
         end
      end
      rsp_steady = 0;
      send_steady = 0;
   endtask

   initial begin
      last_set = 0;
      second_last_set = 0;
      seq_phase = 0;
      rev_mode = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_table_load();
      test_letters();
      test_special_cases();
      test_backpressure();
      test_random(1900);
      set_reverse(1);
      wait_drain();
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
